// File: rtl/crp_pkg.sv
package crp_pkg;

  localparam int unsigned ChW       = 8;
  localparam int unsigned RowW      = 10;
  localparam int unsigned ColW      = 15;
  localparam int unsigned CntW      = 2;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 15;

  localparam logic [CntW-1:0] MAX_LETTERS = 2'd3;
  localparam logic [RowW-1:0] ROW_SAT     = 10'd1000;
  localparam logic [RowW-1:0] ROW_CAP     = 10'd999;
  localparam logic [RowW-1:0] ROWS_RESET  = 10'd999;
  localparam logic [ColW-1:0] COLS_RESET  = 15'd18278;

  localparam logic [ChW-1:0] CH_UPPER_A = 8'h41;
  localparam logic [ChW-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [ChW-1:0] CH_LOWER_A = 8'h61;
  localparam logic [ChW-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [ChW-1:0] CH_ZERO    = 8'h30;
  localparam logic [ChW-1:0] CH_NINE    = 8'h39;

  localparam logic [CfgIdxW-1:0] REG_MAX_ROWS = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_COLS = 1'd1;

  typedef enum logic [1:0] {
    PH_LETTERS = 2'd0,
    PH_DIGITS  = 2'd1,
    PH_DONE    = 2'd2,
    PH_INVALID = 2'd3
  } phase_t;

  typedef struct packed {
    phase_t            phase;
    logic [CntW-1:0]   letter_count;
    logic [ColW-1:0]   col_acc;
    logic [RowW-1:0]   row_acc;
  } parse_state_t;

  typedef struct packed {
    logic            ok;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
  } parse_res_t;

  localparam parse_state_t STATE_CLEAR = '{
    phase:        PH_LETTERS,
    letter_count: '0,
    col_acc:      '0,
    row_acc:      '0
  };

endpackage

// File: rtl/cell_reference_parser.sv
// Cell reference parser for spreadsheet names in A1 notation, such as B12.
// The name arrives one character per request on the input channel (ch, with
// last marking the final character). Each request is accepted at a rising
// edge with in_valid high and in_stall low. Only the request flagged last
// produces a result request on the output channel: valid_res, row_index and
// col_index, taken at an edge with out_valid high and out_stall low.
// A character accepted lands in the input register; its result is then
// registered in the output register. Throughput: one character per cycle
// while in_stall is low, set by the combinational update of the parse
// state (a shift-and-add times 26 or times 10, and a bound compare).
// When the receiver stalls, a finished result waits in the output register
// while further characters of the next name keep flowing; only a second
// last-flagged character backs up, raising in_stall until the slot frees.
// Reset (rst, synchronous) empties both registers, clears the parse state
// and loads max_rows = 999 and max_cols = 18278. The configuration port
// (cfg_we, cfg_index, cfg_data) writes a register and should be used only
// while no name is in flight.
module cell_reference_parser
  import crp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // Character requests.
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ChW-1:0]      ch,
  input  logic                last,
  // Result requests.
  output logic                out_valid,
  input  logic                out_stall,
  output logic                valid_res,
  output logic [RowW-1:0]     row_index,
  output logic [ColW-1:0]     col_index,
  // Configuration writes.
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  // Input register.
  logic           in_full;
  logic [ChW-1:0] ch_q;
  logic           last_q;

  // Parse state, carried across the characters of one name.
  parse_state_t st;
  parse_state_t st_next;
  parse_res_t   res_next;

  logic [RowW-1:0] max_rows;
  logic [ColW-1:0] max_cols;

  logic advance;
  logic out_free;

  // The output slot can take a new result when empty or being emptied now.
  assign out_free = !out_valid || !out_stall;
  // Characters that are not last never need the output slot.
  assign advance  = in_full && (!last_q || out_free);
  // The input register accepts whenever it is empty or moving on this cycle.
  assign in_stall = in_full && !advance;

  crp_step u_step (
    .cur      (st),
    .ch       (ch_q),
    .max_rows (max_rows),
    .max_cols (max_cols),
    .nxt      (st_next),
    .res      (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
    if (in_valid && !in_stall) begin
      ch_q   <= ch;
      last_q <= last;
    end
  end

  // A finished name returns the parser to its cleared state.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_CLEAR;
    end else if (advance) begin
      st <= last_q ? STATE_CLEAR : st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && last_q) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance && last_q) begin
      valid_res <= res_next.ok;
      row_index <= res_next.row;
      col_index <= res_next.col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_rows <= ROWS_RESET;
      max_cols <= COLS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_ROWS: max_rows <= cfg_data[RowW-1:0];
        REG_MAX_COLS: max_cols <= cfg_data[ColW-1:0];
        default: begin
        end
      endcase
    end
  end

  // An invalid name reports zero row and column.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> row_index == '0 && col_index == '0)
    else $error("invalid result carries nonzero indexes");

  // A reported row is always below the row cap.
  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && valid_res |-> row_index < ROW_CAP)
    else $error("row index out of range");

  // The end of a name leaves the parse state cleared.
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    advance && last_q |=> st == STATE_CLEAR)
    else $error("parse state not cleared after last character");

  // Backpressure only appears with a held character that needs the slot.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_full && last_q && out_valid && out_stall)
    else $error("input stalled without cause");

  // A stalled result is never overwritten by the next name.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !(advance && last_q))
    else $error("pending result overwritten");

endmodule

// File: rtl/crp_step.sv
module crp_step
  import crp_pkg::*;
(
  input  parse_state_t    cur,
  input  logic [ChW-1:0]  ch,
  input  logic [RowW-1:0] max_rows,
  input  logic [ColW-1:0] max_cols,
  output parse_state_t    nxt,
  output parse_res_t      res
);

  logic            is_upper;
  logic            is_lower;
  logic            is_digit;
  logic [3:0]      digit;
  logic [ColW-1:0] letter;
  logic [ColW-1:0] col_prod;
  logic [13:0]     row_prod;
  logic [RowW-1:0] rows_lim;

  assign is_upper = ch inside {[CH_UPPER_A:CH_UPPER_Z]};
  assign is_lower = ch inside {[CH_LOWER_A:CH_LOWER_Z]};
  assign is_digit = ch inside {[CH_ZERO:CH_NINE]};
  assign digit    = 4'(ch - CH_ZERO);
  assign letter   = ColW'(ch - CH_UPPER_A) + ColW'(1);

  // Column times 26 as shifts; at most two letters precede the multiply,
  // so the product stays well inside the column width.
  assign col_prod = (cur.col_acc << 4) + (cur.col_acc << 3) + (cur.col_acc << 1) + letter;
  assign row_prod = ({4'b0, cur.row_acc} << 3) + ({4'b0, cur.row_acc} << 1) + {10'b0, digit};

  always_comb begin
    nxt = cur;
    case (cur.phase)
      PH_LETTERS: begin
        if ((is_upper || is_lower) && cur.letter_count < MAX_LETTERS) begin
          if (is_lower) begin
            nxt.phase = PH_INVALID;
          end else begin
            nxt.col_acc      = col_prod;
            nxt.letter_count = cur.letter_count + CntW'(1);
          end
        end else if (is_digit && cur.letter_count != '0) begin
          nxt.phase   = PH_DIGITS;
          nxt.row_acc = {6'b0, digit};
        end else begin
          nxt.phase = PH_INVALID;
        end
      end
      PH_DIGITS: begin
        if (is_digit) begin
          nxt.row_acc = (row_prod > {4'b0, ROW_SAT}) ? ROW_SAT : row_prod[RowW-1:0];
        end else begin
          nxt.phase = PH_DONE;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

  assign rows_lim = (max_rows > ROW_CAP) ? ROW_CAP : max_rows;

  always_comb begin
    res.ok = (nxt.phase == PH_DIGITS || nxt.phase == PH_DONE) &&
             nxt.row_acc != '0 && nxt.row_acc <= rows_lim &&
             nxt.col_acc != '0 && nxt.col_acc <= max_cols;
    res.row = res.ok ? nxt.row_acc - RowW'(1) : '0;
    res.col = res.ok ? nxt.col_acc - ColW'(1) : '0;
  end

endmodule

// File: tb/sv/cell_reference_parser_test.sv
`timescale 1ns / 100ps

module cell_reference_parser_test;
  import crp_pkg::*;

  // The run is stopped by force if it is still going after this many cycles.
  // A correct run stays well below this limit even when every gap and stall is
  // as long as it can be, so this leaves a wide margin.
  localparam int CYCLE_LIMIT = 200000;

  // The number of cycles allowed after the last result before the block is
  // treated as idle. A character lands in the input register at the edge
  // that takes it, and its result is then registered in the output register.
  localparam int SETTLE_CYCLES = 4;

  // One character request as the sender holds it before driving it.
  typedef struct {
    logic [ChW-1:0] code;
    logic           fin;
  } char_req_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;

  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [ChW-1:0]      ch = '0;
  logic                last = 1'b0;

  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                valid_res;
  logic [RowW-1:0]     row_index;
  logic [ColW-1:0]     col_index;

  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  cell_reference_parser u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .ch        (ch),
    .last      (last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .valid_res (valid_res),
    .row_index (row_index),
    .col_index (col_index),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Characters waiting to be driven, and the parse results expected back,
  // oldest first.
  char_req_t  char_q[$];
  parse_res_t cell_results_q[$];

  // Our own copy of the parser: the name being read and the two limits.
  phase_t          name_phase   = PH_LETTERS;
  int              letters_seen = 0;
  int              col_sum      = 0;
  int              row_sum      = 0;
  logic [RowW-1:0] rows_in_use  = ROWS_RESET;
  logic [ColW-1:0] cols_in_use  = COLS_RESET;

  // Idling controls. While idle_on is clear neither side inserts gaps.
  bit idle_on    = 1'b1;
  bit drain_wait = 1'b0;
  int send_gap   = 0;
  int stall_left = 0;

  int n_errors        = 0;
  int chars_queued    = 0;
  int chars_accepted  = 0;
  int results_checked = 0;
  int settings_used   = 1;
  int cycle_count     = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // Advance the parser copy by one character. On the last character of a
  // name, the verdict is pushed as the next expected result and the name
  // state starts over; the two limits stay as they are.
  function automatic void parse_char(logic [ChW-1:0] c, logic fin);
    logic       is_upper;
    logic       is_lower;
    logic       is_digit;
    int         next_row;
    int         row_limit;
    logic       ok;
    parse_res_t res;
    is_upper = (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
    is_lower = (c >= CH_LOWER_A) && (c <= CH_LOWER_Z);
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    case (name_phase)
      PH_LETTERS: begin
        // A letter is only welcome while there is room for one more; past
        // that, anything but a digit spoils the name.
        if ((is_upper || is_lower) && letters_seen < MAX_LETTERS) begin
          if (is_lower) begin
            name_phase = PH_INVALID;
          end else begin
            col_sum = col_sum * 26 + int'(c - CH_UPPER_A) + 1;
            letters_seen++;
          end
        end else if (is_digit && letters_seen > 0) begin
          name_phase = PH_DIGITS;
          row_sum = int'(c - CH_ZERO);
        end else begin
          name_phase = PH_INVALID;
        end
      end
      PH_DIGITS: begin
        // The row saturates rather than wraps; the first non-digit ends it.
        if (is_digit) begin
          next_row = row_sum * 10 + int'(c - CH_ZERO);
          row_sum = (next_row > int'(ROW_SAT)) ? int'(ROW_SAT) : next_row;
        end else begin
          name_phase = PH_DONE;
        end
      end
      default: ;
    endcase
    if (fin) begin
      // A row limit above the top row still only admits rows up to it.
      row_limit = (rows_in_use > ROW_CAP) ? int'(ROW_CAP) : int'(rows_in_use);
      ok = (name_phase == PH_DIGITS || name_phase == PH_DONE) &&
           row_sum >= 1 && row_sum <= row_limit &&
           col_sum >= 1 && col_sum <= int'(cols_in_use);
      res.ok  = ok;
      res.row = ok ? RowW'(row_sum - 1) : '0;
      res.col = ok ? ColW'(col_sum - 1) : '0;
      cell_results_q.push_back(res);
      name_phase   = PH_LETTERS;
      letters_seen = 0;
      col_sum      = 0;
      row_sum      = 0;
    end
  endfunction

  // Sender. A character is taken at an edge where in_valid is high and
  // in_stall is low; that is the moment the parser copy sees it. A new
  // character is loaded only when the port is empty or was just emptied, so
  // a stalled request keeps its payload.
  always @(posedge clk) begin : char_driver
    char_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      ch       <= '0;
      last     <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        parse_char(ch, last);
        chars_accepted++;
        // Now and then hold back until every result has come out, so the
        // block drains completely in the middle of a stream.
        if (last && idle_on && $urandom_range(0, 39) == 0) drain_wait = 1'b1;
      end
      if (!idle_on) send_gap = 0;
      if (!in_valid || !in_stall) begin
        if (drain_wait && cell_results_q.size() == 0) drain_wait = 1'b0;
        if (drain_wait || send_gap > 0) begin
          if (send_gap > 0) send_gap--;
          in_valid <= 1'b0;
        end else if (char_q.size() > 0) begin
          nxt = char_q.pop_front();
          in_valid <= 1'b1;
          ch       <= nxt.code;
          last     <= nxt.fin;
          if (idle_on && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 14);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Every result taken is checked field by field against the
  // oldest expectation. The stall comes in random bursts.
  always @(posedge clk) begin : result_monitor
    parse_res_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (cell_results_q.size() == 0) begin
          $error("result with no name pending: valid_res %0d row_index %0d col_index %0d",
                 valid_res, row_index, col_index);
          n_errors++;
        end else begin
          want = cell_results_q.pop_front();
          results_checked++;
          if (valid_res !== want.ok) begin
            $error("valid_res: expected %0d, got %0d", want.ok, valid_res);
            n_errors++;
          end
          if (row_index !== want.row) begin
            $error("row_index: expected %0d, got %0d", want.row, row_index);
            n_errors++;
          end
          if (col_index !== want.col) begin
            $error("col_index: expected %0d, got %0d", want.col, col_index);
            n_errors++;
          end
        end
      end
      if (!idle_on) stall_left = 0;
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (idle_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 14);
      end
    end
  end

  // Watchdog: a lost or stuck result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_char(logic [ChW-1:0] code, logic fin);
    char_req_t req;
    req.code = code;
    req.fin  = fin;
    char_q.push_back(req);
    chars_queued++;
  endtask

  task automatic queue_name(string s);
    int i;
    for (i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
  endtask

  // Queue random names until about n_chars characters are waiting. Most are
  // well formed with random letters and digits, some carry junk after the
  // row, and the rest are broken names and plain noise.
  task automatic queue_random_names(int n_chars);
    logic [ChW-1:0] txt[$];
    int             start;
    int             kind;
    int             n_letters;
    int             n_digits;
    int             pos;
    int             i;
    start = chars_queued;
    while (chars_queued - start < n_chars) begin
      txt.delete();
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
        // The smallest cell, sometimes with a leading zero on the row, so
        // that tight limits still see valid names.
        txt.push_back(CH_UPPER_A);
        if ($urandom_range(0, 2) == 0) txt.push_back(CH_ZERO);
        txt.push_back(8'(CH_ZERO + 1));
      end else if (kind >= 90) begin
        n_letters = $urandom_range(1, 5);
        repeat (n_letters) txt.push_back(8'($urandom_range(0, 255)));
      end else begin
        // Names in the 80s have one or two letters too many.
        n_letters = (kind >= 80) ? $urandom_range(4, 5) : $urandom_range(1, 3);
        repeat (n_letters) begin
          txt.push_back(($urandom_range(0, 4) == 0) ? CH_UPPER_A
                                                    : 8'(CH_UPPER_A + $urandom_range(0, 25)));
        end
        // Long digit strings can push the row into saturation.
        n_digits = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 7) : $urandom_range(1, 3);
        repeat (n_digits) txt.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) txt.push_back(8'($urandom_range(0, 255)));
        end
        // Names in the 70s get one character spoiled, by a lower-case letter
        // or by any code at all.
        if (kind >= 70 && kind < 80) begin
          pos = $urandom_range(0, txt.size() - 1);
          txt[pos] = $urandom_range(0, 1) ? 8'(CH_LOWER_A + $urandom_range(0, 25))
                                          : 8'($urandom_range(0, 255));
        end
      end
      for (i = 0; i < txt.size(); i++) push_char(txt[i], i == txt.size() - 1);
    end
  endtask

  // Wait until the sender is empty and every result has come back, then
  // let the block settle before calling it idle.
  task automatic wait_idle();
    while (char_q.size() > 0 || in_valid || cell_results_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register and keep our copy of the limits in step. Only the
  // low bits of the data that fit the register are kept.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_MAX_ROWS) rows_in_use = val[RowW-1:0];
    else cols_in_use = val[ColW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed names under the limits set by reset: the first and the last
    // cell of the sheet, a lower-case letter, four letters, no letter at all,
    // an empty name, junk after the row that must be ignored, and row zero.
    queue_name("A1");
    queue_name("ZZZ999");
    queue_name("a1");
    queue_name("ABCD1");
    queue_name("12");
    push_char('0, 1'b1);
    queue_name("B12x3");
    queue_name("A0");
    wait_idle();

    // The tightest limits that still allow a cell. The row limit is written
    // with high bits set that the register has no room for.
    write_reg(REG_MAX_ROWS, 15'h7C01);
    write_reg(REG_MAX_COLS, 15'd1);
    settings_used++;
    queue_random_names(80);
    wait_idle();

    // Zero limits: nothing can be valid.
    write_reg(REG_MAX_ROWS, '0);
    write_reg(REG_MAX_COLS, '0);
    settings_used++;
    queue_random_names(40);
    wait_idle();

    // All ones: the row limit is capped, so a saturated row stays invalid.
    write_reg(REG_MAX_ROWS, 15'h03FF);
    write_reg(REG_MAX_COLS, 15'h7FFF);
    settings_used++;
    queue_random_names(120);
    wait_idle();

    write_reg(REG_MAX_ROWS, CfgDataW'($urandom_range(1, 999)));
    write_reg(REG_MAX_COLS, CfgDataW'($urandom_range(1, 18278)));
    settings_used++;
    queue_random_names(200);
    wait_idle();

    // The last stretch runs back to back with no gaps and no stalls.
    idle_on = 1'b0;
    write_reg(REG_MAX_ROWS, CfgDataW'(ROWS_RESET));
    write_reg(REG_MAX_COLS, COLS_RESET);
    settings_used++;
    queue_random_names(260);
    wait_idle();

    $display("parse run: %0d characters taken, %0d cell results checked, %0d limit settings",
             chars_accepted, results_checked, settings_used);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
